FILE: design/efsd_pkg.sv
// efsd_pkg: shared sizes, codes and payload types of the earliest-free server dispatch.
// Used by every module in the design folder; depends on nothing.
package efsd_pkg;

	localparam int MAX_SERVERS = 16;
	localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int CNT_W = $clog2(MAX_SERVERS + 1);

	localparam int DUR_W = 20;
	localparam int FIN_W = 40;
	localparam int PID_W = 24;
	localparam int TOT_W = 48;
	localparam int LAT_W = 5;
	localparam int NS_W = 5;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int RIDX_W = PADDR_W - 2;

	localparam logic [RIDX_W-1:0] REG_NUM_SERVERS = RIDX_W'(0);
	localparam logic [NS_W-1:0] NUM_SERVERS_RST = NS_W'(16);

	localparam logic FUNC_ARRIVE = 1'b0;
	localparam logic FUNC_DRAIN = 1'b1;

	typedef struct packed {
		logic func;
		logic [DUR_W-1:0] duration;
	} req_t;

	typedef struct packed {
		logic [PID_W-1:0] person_id;
		logic from_drain;
		logic is_last;
		logic [TOT_W-1:0] total_duration;
		logic [LAT_W-1:0] latest_server;
	} rsp_t;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_ASCAN  = 7'b0000010,
		ST_AUPD   = 7'b0000100,
		ST_LSCAN  = 7'b0001000,
		ST_DSCAN  = 7'b0010000,
		ST_DEMIT  = 7'b0100000,
		ST_DEMPTY = 7'b1000000
	} state_t;

endpackage

FILE: design/efsd_alu.sv
// efsd_alu: the shared finish-time unit, one less-than compare and one saturating add.
// Depends on efsd_pkg.
module efsd_alu (
	input  logic [efsd_pkg::FIN_W-1:0] a,
	input  logic [efsd_pkg::FIN_W-1:0] b,
	output logic                       lt,
	output logic [efsd_pkg::FIN_W-1:0] sum_sat
);
	import efsd_pkg::*;

	logic [FIN_W:0] sum;

	assign lt = (a < b);
	assign sum = {1'b0, a} + {1'b0, b};
	// clamp at all ones on carry out
	assign sum_sat = sum[FIN_W] ? {FIN_W{1'b1}} : sum[FIN_W-1:0];

endmodule

FILE: design/efsd_obuf.sv
// efsd_obuf: result register parting the sequencer from the result channel.
// Depends on efsd_pkg.
module efsd_obuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	output logic                ready,
	input  efsd_pkg::rsp_t      din,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output efsd_pkg::rsp_t      rsp
);
	import efsd_pkg::*;

	logic valid_q;
	rsp_t data_q;

	assign ready = !valid_q || !rsp_stall;
	assign rsp_valid = valid_q;
	assign rsp = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= din;
		end
	end

endmodule

FILE: design/earliest_free_server_dispatch.sv
// earliest_free_server_dispatch: top level, sequencer and server tables.
// Depends on efsd_pkg, efsd_alu and efsd_obuf.
//
// Usage
//  Request channel (req_valid/req_stall/req): func 0 is an arrival with a
//  duration, func 1 a drain. req_stall is high while a request is in work.
//  Result channel (rsp_valid/rsp_stall/rsp): one registered result slot.
//  Config: APB-style, num_servers at byte address 0, pready tied high;
//  write only while the block is idle.
//  Sequence (n = servers in use, m = occupied servers at a drain):
//   arrival onto a free server: taken in idle, no result;
//   arrival onto a full pool: accept, min-scan over n servers, then update;
//   drain: accept, latest-scan over m servers, then per result a scan over
//   m servers and an emit; an empty drain goes from accept straight to its emit.
//  All scans go through the one shared compare/add unit (efsd_alu), one
//  table entry per cycle.
//  Stalling: the sequencer waits in whichever state emits a result while
//  the result slot is full and stalled; nothing is dropped.
//  Reset: pool empty, numbering at 1, total 0, num_servers 16. A drain
//  ends by returning the pool to this state, num_servers kept.
module earliest_free_server_dispatch (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  efsd_pkg::req_t                req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output efsd_pkg::rsp_t                rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [efsd_pkg::PADDR_W-1:0]  paddr,
	input  logic [efsd_pkg::PDATA_W-1:0]  pwdata,
	output logic [efsd_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import efsd_pkg::*;

	// control state
	state_t                 state_q;
	logic [NS_W-1:0]        ns_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [PID_W-1:0]       next_q;
	logic [TOT_W-1:0]       total_q;
	logic [MAX_SERVERS-1:0] mark_q;
	logic [IDX_W-1:0]       idx_q;
	logic [CNT_W-1:0]       k_q;
	logic                   have_q;

	// payload
	logic [FIN_W-1:0] fin_q [MAX_SERVERS];
	logic [PID_W-1:0] occ_q [MAX_SERVERS];
	logic [IDX_W-1:0] best_q;
	logic [IDX_W-1:0] lat_q;
	logic [FIN_W-1:0] ref_q;
	logic [DUR_W-1:0] dur_q;
	logic [PID_W-1:0] person_q;

	logic [CNT_W-1:0] n_eff;
	logic [CNT_W-1:0] occ;
	logic             accept;
	logic             cfg_wr;
	logic [FIN_W-1:0] fin_rd;
	logic [FIN_W-1:0] alu_a;
	logic [FIN_W-1:0] alu_b;
	logic             alu_lt;
	logic [FIN_W-1:0] alu_sum;
	logic [TOT_W:0]   tot_sum;
	logic [TOT_W-1:0] tot_next;
	logic [PID_W-1:0] pid_next;
	logic             scan_end_n;
	logic             scan_end_m;
	logic             emit_last;
	logic             obuf_load;
	logic             obuf_ready;
	rsp_t             res;

	// ---- configuration port ----
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[PADDR_W-1:2] == REG_NUM_SERVERS);
	assign prdata = (paddr[PADDR_W-1:2] == REG_NUM_SERVERS) ? PDATA_W'(ns_q) : '0;

	// servers in use: zero acts as one, clamp to the built count
	always_comb begin
		if (ns_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (int'(ns_q) > MAX_SERVERS) begin
			n_eff = CNT_W'(MAX_SERVERS);
		end else begin
			n_eff = CNT_W'(ns_q);
		end
	end

	// only the first n_eff servers count when the pool was shrunk
	assign occ = (cnt_q < n_eff) ? cnt_q : n_eff;

	assign req_stall = (state_q != ST_IDLE);
	assign accept = req_valid && !req_stall;

	// ---- shared unit operands ----
	assign fin_rd = fin_q[idx_q];
	always_comb begin
		if (state_q == ST_AUPD) begin
			alu_a = ref_q;
			alu_b = FIN_W'(dur_q);
		end else begin
			alu_a = fin_rd;
			alu_b = ref_q;
		end
	end

	efsd_alu u_alu (
		.a       (alu_a),
		.b       (alu_b),
		.lt      (alu_lt),
		.sum_sat (alu_sum)
	);

	// total saturates, numbering wraps to 1 and skips 0
	assign tot_sum = {1'b0, total_q} + (TOT_W + 1)'(req.duration);
	assign tot_next = tot_sum[TOT_W] ? {TOT_W{1'b1}} : tot_sum[TOT_W-1:0];
	assign pid_next = (next_q == {PID_W{1'b1}}) ? PID_W'(1) : next_q + PID_W'(1);

	assign scan_end_n = (CNT_W'(idx_q) == n_eff - CNT_W'(1));
	assign scan_end_m = (CNT_W'(idx_q) == occ - CNT_W'(1));
	assign emit_last = (k_q + CNT_W'(1) == occ);

	// ---- result assembly ----
	always_comb begin
		res = '0;
		obuf_load = 1'b0;
		unique case (state_q)
			ST_AUPD: begin
				res.person_id = occ_q[best_q];
				res.is_last = 1'b1;
				obuf_load = obuf_ready;
			end
			ST_DEMIT: begin
				res.person_id = occ_q[best_q];
				res.from_drain = 1'b1;
				if (emit_last) begin
					res.is_last = 1'b1;
					res.total_duration = total_q;
					res.latest_server = LAT_W'(CNT_W'(lat_q) + CNT_W'(1));
				end
				obuf_load = obuf_ready;
			end
			ST_DEMPTY: begin
				res.from_drain = 1'b1;
				res.is_last = 1'b1;
				res.total_duration = total_q;
				obuf_load = obuf_ready;
			end
			default: begin
				obuf_load = 1'b0;
			end
		endcase
	end

	efsd_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (obuf_load),
		.ready     (obuf_ready),
		.din       (res),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ns_q <= NUM_SERVERS_RST;
			cnt_q <= '0;
			next_q <= PID_W'(1);
			total_q <= '0;
			mark_q <= '0;
			idx_q <= '0;
			k_q <= '0;
			have_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				ns_q <= pwdata[NS_W-1:0];
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						if (req.func == FUNC_ARRIVE) begin
							next_q <= pid_next;
							total_q <= tot_next;
							if (occ < n_eff) begin
								cnt_q <= occ + CNT_W'(1);
							end else begin
								state_q <= ST_ASCAN;
							end
						end else if (occ == '0) begin
							state_q <= ST_DEMPTY;
						end else begin
							state_q <= ST_LSCAN;
						end
					end
				end
				ST_ASCAN: begin
					if (scan_end_n) begin
						state_q <= ST_AUPD;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_AUPD: begin
					if (obuf_ready) begin
						state_q <= ST_IDLE;
					end
				end
				ST_LSCAN: begin
					if (scan_end_m) begin
						mark_q <= '0;
						idx_q <= '0;
						have_q <= 1'b0;
						k_q <= '0;
						state_q <= ST_DSCAN;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_DSCAN: begin
					if (!mark_q[idx_q] && (!have_q || alu_lt)) begin
						have_q <= 1'b1;
					end
					if (scan_end_m) begin
						state_q <= ST_DEMIT;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_DEMIT: begin
					if (obuf_ready) begin
						if (emit_last) begin
							// pool back to its reset state
							cnt_q <= '0;
							next_q <= PID_W'(1);
							total_q <= '0;
							mark_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							mark_q[best_q] <= 1'b1;
							k_q <= k_q + CNT_W'(1);
							idx_q <= '0;
							have_q <= 1'b0;
							state_q <= ST_DSCAN;
						end
					end
				end
				ST_DEMPTY: begin
					if (obuf_ready) begin
						cnt_q <= '0;
						next_q <= PID_W'(1);
						total_q <= '0;
						mark_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ---- tables and scan payload ----
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (req.func == FUNC_ARRIVE)) begin
					person_q <= next_q;
					dur_q <= req.duration;
					if (occ < n_eff) begin
						fin_q[occ[IDX_W-1:0]] <= FIN_W'(req.duration);
						occ_q[occ[IDX_W-1:0]] <= next_q;
					end
				end
			end
			ST_ASCAN: begin
				// least finish, first index wins ties
				if ((idx_q == '0) || alu_lt) begin
					best_q <= idx_q;
					ref_q <= fin_rd;
				end
			end
			ST_AUPD: begin
				if (obuf_ready) begin
					occ_q[best_q] <= person_q;
					fin_q[best_q] <= alu_sum;
				end
			end
			ST_LSCAN: begin
				// greatest finish, last index wins ties
				if ((idx_q == '0) || !alu_lt) begin
					lat_q <= idx_q;
					ref_q <= fin_rd;
				end
			end
			ST_DSCAN: begin
				if (!mark_q[idx_q] && (!have_q || alu_lt)) begin
					best_q <= idx_q;
					ref_q <= fin_rd;
				end
			end
			default: begin
			end
		endcase
	end

	// ---- assertions ----
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> req_stall)
		else $error("request taken while busy");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cnt_q) <= MAX_SERVERS)
		else $error("occupied count beyond pool");

	a_no_double: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DEMIT) |-> (have_q && !mark_q[best_q]))
		else $error("drain emits a server twice or none");

	a_mid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.is_last) |-> rsp.from_drain)
		else $error("non-last result outside a drain");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(obuf_load && (state_q == ST_DEMPTY)) |=> (rsp_valid && rsp.is_last))
		else $error("empty drain result lost");

endmodule
